// ===== rtl/fbbc_pkg.sv =====
package fbbc_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 32;
    localparam int EVC_W  = 7;

    localparam logic [EVC_W-1:0] EVICT_SAT = '1;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_ERASE = 2'd1;
    localparam logic [1:0] ACT_GET   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_REJ  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic              flag;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

endpackage

// ===== rtl/fbbc_mem.sv =====
module fbbc_mem
    import fbbc_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry mem [MAX_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fifo_byte_budget_cache.sv =====
// Insertion-ordered key cache under a byte budget. Pulse start while busy is low to issue
// one put, erase or get; exactly one result follows, shown for a single cycle with o_strobe
// high, and the receiver has no way to stall it, so it must sample every strobe. A rejected
// put or an unknown action answers in the cycle after acceptance. Otherwise the entry store
// (one read port with registered data, one write port) sets the pace: the key search reads
// and compares each stored entry in turn, removing a found entry moves each newer entry
// down one slot, and a put evicts oldest entries one at a time before it appends.
// Configuration writes are to be made only while idle; the block itself does not enforce this.
module fifo_byte_budget_cache
    import fbbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_action,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [SIZE_W-1:0] i_entry_size,
    input  logic              i_entry_validated,
    input  logic              i_need_validated,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [SIZE_W-1:0] o_found_size,
    output logic              o_found_validated,
    output logic [EVC_W-1:0]  o_evicted_count,
    output logic [SIZE_W-1:0] o_used_bytes
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_ECHK = 3'd5;
    localparam logic [2:0] S_ESUB = 3'd6;

    function automatic logic [IDX_W-1:0] ring_addr(logic [IDX_W-1:0] base,
                                                   logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
        if (sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
            sum = sum - (CNT_W+1)'(MAX_ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [2:0]        r_state, n_state;
    logic [31:0]       r_cap;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SIZE_W-1:0] r_bytes, n_bytes;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [EVC_W-1:0]  r_evc, n_evc;

    logic [1:0]        r_act;
    logic [KEY_W-1:0]  r_key;
    logic [SIZE_W-1:0] r_size;
    logic              r_vflag;
    logic              r_need;

    logic              r_stb, n_stb;
    logic [1:0]        r_ostat, n_ostat;
    logic [SIZE_W-1:0] r_ofsize, n_ofsize;
    logic              r_offlag, n_offlag;
    logic [EVC_W-1:0]  r_oevc, n_oevc;
    logic [SIZE_W-1:0] r_oused;

    t_mem_wr           mem_wr;
    logic [IDX_W-1:0]  mem_raddr;
    t_entry            mem_rdata;
    logic              accept;
    logic              evict_need;

    fbbc_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept = start && (r_state == S_IDLE);
    // The size was checked against the budget at acceptance, so the subtraction cannot wrap.
    assign evict_need = (r_count != '0) &&
                        ((r_bytes > (r_cap - r_size)) ||
                         (r_count >= CNT_W'(MAX_ENTRIES)));

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_idx    = r_idx;
        n_evc    = r_evc;
        n_stb    = 1'b0;
        n_ostat  = ST_OK;
        n_ofsize = '0;
        n_offlag = 1'b0;
        n_oevc   = '0;
        mem_wr   = '0;
        mem_raddr = ring_addr(r_head, r_idx);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_evc = '0;
                    if ((i_action == ACT_PUT &&
                         (i_key == '0 || i_entry_size > r_cap)) ||
                        (i_action != ACT_PUT && i_action != ACT_ERASE &&
                         i_action != ACT_GET)) begin
                        n_stb   = 1'b1;
                        n_ostat = ST_REJ;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                mem_raddr = ring_addr(r_head, r_idx);
                if (r_idx == r_count) begin
                    if (r_act == ACT_PUT) begin
                        n_state = S_ECHK;
                    end else begin
                        n_state = S_IDLE;
                        n_stb   = 1'b1;
                        n_ostat = ST_MISS;
                    end
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (mem_rdata.key == r_key) begin
                    if (r_act == ACT_GET) begin
                        n_state = S_IDLE;
                        n_stb   = 1'b1;
                        if (r_need && !mem_rdata.flag) begin
                            n_ostat = ST_MISS;
                        end else begin
                            n_ofsize = mem_rdata.size;
                            n_offlag = mem_rdata.flag;
                        end
                    end else begin
                        n_bytes = r_bytes - mem_rdata.size;
                        n_state = S_MRD;
                    end
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                mem_raddr = ring_addr(r_head, r_idx + CNT_W'(1));
                if ((r_idx + CNT_W'(1)) == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_act == ACT_PUT) begin
                        n_state = S_ECHK;
                    end else begin
                        n_state = S_IDLE;
                        n_stb   = 1'b1;
                    end
                end else begin
                    n_state = S_MWR;
                end
            end
            S_MWR: begin
                // Close the gap left by the removed entry, one newer entry at a time.
                mem_wr.we   = 1'b1;
                mem_wr.addr = ring_addr(r_head, r_idx);
                mem_wr.data = mem_rdata;
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_MRD;
            end
            S_ECHK: begin
                mem_raddr = r_head;
                if (evict_need) begin
                    n_state = S_ESUB;
                end else begin
                    mem_wr.we        = 1'b1;
                    mem_wr.addr      = ring_addr(r_head, r_count);
                    mem_wr.data.key  = r_key;
                    mem_wr.data.size = r_size;
                    mem_wr.data.flag = r_vflag;
                    n_count = r_count + CNT_W'(1);
                    n_bytes = r_bytes + r_size;
                    n_state = S_IDLE;
                    n_stb   = 1'b1;
                    n_oevc  = r_evc;
                end
            end
            S_ESUB: begin
                n_bytes = r_bytes - mem_rdata.size;
                n_head  = (r_head == IDX_W'(MAX_ENTRIES - 1)) ? '0 : r_head + IDX_W'(1);
                n_count = r_count - CNT_W'(1);
                n_evc   = (r_evc == EVICT_SAT) ? r_evc : r_evc + EVC_W'(1);
                n_state = S_ECHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= 32'd1048576;
            r_head  <= '0;
            r_count <= '0;
            r_bytes <= '0;
            r_idx   <= '0;
            r_evc   <= '0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_bytes <= n_bytes;
            r_idx   <= n_idx;
            r_evc   <= n_evc;
            r_stb   <= n_stb;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= i_action;
            r_key   <= i_key;
            r_size  <= i_entry_size;
            r_vflag <= i_entry_validated;
            r_need  <= i_need_validated;
        end
        if (n_stb) begin
            r_ostat  <= n_ostat;
            r_ofsize <= n_ofsize;
            r_offlag <= n_offlag;
            r_oevc   <= n_oevc;
            r_oused  <= n_bytes;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_stb;
    assign o_status          = r_ostat;
    assign o_found_size      = r_ofsize;
    assign o_found_validated = r_offlag;
    assign o_evicted_count   = r_oevc;
    assign o_used_bytes      = r_oused;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted item neither in work nor answered");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while sequencer still busy");

    a_put_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_act == ACT_PUT && o_status == ST_OK) |-> (o_used_bytes <= r_cap))
        else $error("stored bytes exceed budget after put");

    a_evict_put_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_act != ACT_PUT) |-> (o_evicted_count == '0))
        else $error("evictions reported on a non-put item");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_bytes == '0))
        else $error("byte total nonzero with empty table");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fbbc_pkg::*;

    // The action field is two bits wide, so the one unused code is exercised too.
    localparam logic [1:0]  ACT_BAD        = 2'd3;
    localparam logic [31:0] DEFAULT_BUDGET = 32'd1048576;
    localparam int          POOL           = 96;
    localparam int          DRAIN_CYCLES   = 450;

    typedef struct packed {
        logic [1:0]        action;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic              vflag;
        logic              need;
    } t_op;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIZE_W-1:0] found_size;
        logic              found_validated;
        logic [EVC_W-1:0]  evicted;
        logic [SIZE_W-1:0] used;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [31:0]       i_cfg_wdata = '0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_action = ACT_GET;
    logic [KEY_W-1:0]  i_key = '0;
    logic [SIZE_W-1:0] i_entry_size = '0;
    logic              i_entry_validated = 1'b0;
    logic              i_need_validated = 1'b0;
    logic              o_strobe;
    logic [1:0]        o_status;
    logic [SIZE_W-1:0] o_found_size;
    logic              o_found_validated;
    logic [EVC_W-1:0]  o_evicted_count;
    logic [SIZE_W-1:0] o_used_bytes;

    fifo_byte_budget_cache dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_key             (i_key),
        .i_entry_size      (i_entry_size),
        .i_entry_validated (i_entry_validated),
        .i_need_validated  (i_need_validated),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_found_size      (o_found_size),
        .o_found_validated (o_found_validated),
        .o_evicted_count   (o_evicted_count),
        .o_used_bytes      (o_used_bytes)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the cache contents, oldest entry in slot 0.
    logic [KEY_W-1:0]  cache_keys  [MAX_ENTRIES];
    logic [SIZE_W-1:0] cache_sizes [MAX_ENTRIES];
    logic              cache_flags [MAX_ENTRIES];
    int                cache_fill = 0;
    logic [SIZE_W-1:0] cache_bytes = '0;
    logic [31:0]       budget = DEFAULT_BUDGET;

    function automatic int lookup(logic [KEY_W-1:0] k);
        for (int i = 0; i < cache_fill; i++)
            if (cache_keys[i] == k) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int slot);
        cache_bytes -= cache_sizes[slot];
        for (int i = slot; i + 1 < cache_fill; i++) begin
            cache_keys[i]  = cache_keys[i + 1];
            cache_sizes[i] = cache_sizes[i + 1];
            cache_flags[i] = cache_flags[i + 1];
        end
        cache_fill--;
    endfunction

    function automatic t_reply cache_access(t_op op);
        t_reply      r;
        int          slot;
        int unsigned evicted;
        r = '0;
        evicted = 0;
        case (op.action)
            ACT_PUT: begin
                if (op.key == '0 || op.size > budget) begin
                    r.status = ST_REJ;
                end else begin
                    slot = lookup(op.key);
                    if (slot >= 0) drop_slot(slot);
                    // The size check above keeps budget - size from wrapping.
                    while (cache_fill > 0 &&
                           (cache_bytes > budget - op.size || cache_fill >= MAX_ENTRIES)) begin
                        drop_slot(0);
                        evicted++;
                    end
                    cache_keys[cache_fill]  = op.key;
                    cache_sizes[cache_fill] = op.size;
                    cache_flags[cache_fill] = op.vflag;
                    cache_fill++;
                    cache_bytes += op.size;
                end
            end
            ACT_ERASE: begin
                slot = lookup(op.key);
                if (slot < 0) r.status = ST_MISS;
                else drop_slot(slot);
            end
            ACT_GET: begin
                slot = lookup(op.key);
                if (slot < 0 || (op.need && !cache_flags[slot])) begin
                    r.status = ST_MISS;
                end else begin
                    r.found_size      = cache_sizes[slot];
                    r.found_validated = cache_flags[slot];
                end
            end
            default: r.status = ST_REJ;
        endcase
        r.evicted = (evicted > EVICT_SAT) ? EVICT_SAT : EVC_W'(evicted);
        r.used = cache_bytes;
        return r;
    endfunction

    t_op    queued_ops[$];
    t_reply pending_replies[$];
    int     errors = 0;
    int     gap_left = 0;
    bit     steady = 1'b0;

    task automatic present(t_op op);
        i_action          <= op.action;
        i_key             <= op.key;
        i_entry_size      <= op.size;
        i_entry_validated <= op.vflag;
        i_need_validated  <= op.need;
        gap_left = steady ? 0 : $urandom_range(0, 12);
    endtask

    // Request driver: start stays high across back-to-back items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                if (gap_left == 0 && queued_ops.size() > 0) begin
                    present(queued_ops[0]);
                    queued_ops.delete(0);
                end else begin
                    start <= 1'b0;
                end
            end else if (!start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_ops.size() > 0) begin
                    present(queued_ops[0]);
                    queued_ops.delete(0);
                    start <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result monitor. The strobe belongs to an older item than one accepted at the
    // same edge, so it is checked before the new prediction is queued.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: result with none expected: expected nothing, actual status %0d",
                             $time, o_status);
                    errors++;
                end else begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    check_field("status", want.status, o_status);
                    check_field("found_size", want.found_size, o_found_size);
                    check_field("found_validated", want.found_validated, o_found_validated);
                    check_field("evicted_count", want.evicted, o_evicted_count);
                    check_field("used_bytes", want.used, o_used_bytes);
                end
            end
            if (start && !busy)
                pending_replies.insert(pending_replies.size(),
                                       cache_access(t_op'{i_action, i_key, i_entry_size,
                                                          i_entry_validated,
                                                          i_need_validated}));
            if (i_cfg_we)
                budget = i_cfg_wdata;
        end
    end

    logic [KEY_W-1:0] key_pool [POOL];

    task automatic queue_op(logic [1:0] a, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] s,
                            logic v, logic n);
        queued_ops.insert(queued_ops.size(), t_op'{a, k, s, v, n});
    endtask

    function automatic t_op random_op(logic [31:0] cap, logic [31:0] size_max);
        t_op         op;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        op.action = (pick < 45) ? ACT_PUT : (pick < 62) ? ACT_ERASE :
                    (pick < 97) ? ACT_GET : ACT_BAD;
        pick = $urandom_range(0, 99);
        if (pick < 92) op.key = key_pool[$urandom_range(0, POOL - 1)];
        else if (pick < 97) op.key = {$urandom, $urandom};
        else op.key = '0;
        pick = $urandom_range(0, 99);
        if (pick < 85) op.size = $urandom_range(0, size_max);
        else if (pick < 90) op.size = cap;
        else if (pick < 95) op.size = cap + 1;
        else op.size = $urandom;
        op.vflag = 1'($urandom_range(0, 1));
        op.need = 1'($urandom_range(0, 1));
        return op;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_ops.size() != 0 || start || busy || pending_replies.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] cap, int count, logic [31:0] size_max);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        steady = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++)
            queued_ops.insert(queued_ops.size(), random_op(cap, size_max));
    endtask

    initial begin
        logic [31:0] odd_cap;
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        for (int i = 3; i < POOL; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the budget that reset leaves in place.
        queue_op(ACT_GET,   64'd0, 32'd0, 1'b0, 1'b0);
        queue_op(ACT_ERASE, '1, 32'd0, 1'b0, 1'b0);
        queue_op(ACT_PUT,   64'd0, 32'd5, 1'b1, 1'b0);
        queue_op(ACT_PUT,   64'd1, DEFAULT_BUDGET + 1, 1'b1, 1'b0);
        queue_op(ACT_PUT,   '1, DEFAULT_BUDGET, 1'b1, 1'b0);
        queue_op(ACT_GET,   '1, 32'd0, 1'b0, 1'b1);
        queue_op(ACT_PUT,   64'd1, 32'd0, 1'b0, 1'b0);
        queue_op(ACT_PUT,   64'd2, 32'd1, 1'b0, 1'b0);
        queue_op(ACT_GET,   64'd2, 32'd0, 1'b0, 1'b1);
        queue_op(ACT_GET,   64'd2, 32'd0, 1'b0, 1'b0);
        queue_op(ACT_PUT,   64'd1, 32'd5, 1'b1, 1'b0);
        queue_op(ACT_ERASE, 64'd2, 32'd0, 1'b0, 1'b0);
        queue_op(ACT_ERASE, 64'd2, 32'd0, 1'b0, 1'b0);
        queue_op(ACT_BAD,   64'd1, 32'd3, 1'b1, 1'b1);
        queue_op(ACT_GET,   64'd0, 32'd0, 1'b0, 1'b1);
        queue_op(ACT_PUT,   64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_op(ACT_PUT,   64'h5555_5555_5555_5555, 32'h000A_AAAA, 1'b0, 1'b1);
        queue_op(ACT_PUT,   64'hAAAA_AAAA_AAAA_AAAA, 32'h0005_5555, 1'b1, 1'b0);
        queue_op(ACT_GET,   64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 1'b0, 1'b1);
        queue_op(ACT_GET,   64'h5555_5555_5555_5555, 32'd0, 1'b0, 1'b1);

        // A zero budget right after stored bytes forces the first accepted put to clear the table.
        run_phase(32'd0, 60, 32'd2);
        run_phase(32'hFFFF_FFFF, 150, 32'hFFFF_FFFF);
        run_phase(32'd1, 80, 32'd1);
        run_phase(32'd100000, 200, 32'd400);
        run_phase(32'd5000, 150, 32'd600);
        odd_cap = $urandom;
        run_phase(odd_cap, 120, odd_cap >> 4);
        run_phase(DEFAULT_BUDGET, 150, 32'd40000);
        run_phase(32'hFFFF_FFFF, 100, 32'd10);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("** fifo_byte_budget_cache: PASSED **");
        end else begin
            $display("** fifo_byte_budget_cache: FAILED **");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("%0t: timeout", $time);
        $display("** fifo_byte_budget_cache: FAILED **");
        $finish;
    end

endmodule
